FILE: hdl/hgm_pkg.sv
// Shared constants and types for the heightmap grid mesh generator.
// No dependencies; used by every module of the block.
package hgm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Offset added to the texture coordinates for the tiled pair
    localparam int TILE_OFFSET = 3;

    // Fixed field and register widths
    localparam int DIM_W      = 11;
    localparam int STEP_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_XZ_W   = 26;
    localparam int POS_Y_W    = 32;
    localparam int MAP_W      = 17;
    localparam int TILE_W     = 19;
    localparam int IDX_W      = 20;

    // Operand width of the shared multiplier
    localparam int MUL_W = 17;

    // Register reset values
    localparam logic [DIM_W-1:0]  NUM_ROWS_RST     = 11'd2;
    localparam logic [DIM_W-1:0]  NUM_COLS_RST     = 11'd2;
    localparam logic [STEP_W-1:0] ROW_STEP_RST     = 16'd256;
    localparam logic [STEP_W-1:0] COL_STEP_RST     = 16'd256;
    localparam logic [STEP_W-1:0] HEIGHT_SCALE_RST = 16'd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS     = 3'd0,
        CFG_NUM_COLS     = 3'd1,
        CFG_ROW_STEP     = 3'd2,
        CFG_COL_STEP     = 3'd3,
        CFG_HEIGHT_SCALE = 3'd4
    } cfg_idx_t;

endpackage

FILE: hdl/heightmap_grid_mesh_generator.sv
// Heightmap grid mesh generator: one vertex (and quad corners) per height sample.
// A new sample is accepted only once the previous one has left the sequencer for the
// output register; the bit-serial divider computes both texture fractions in turn,
// and three products share one multiplier.
// Reset: config registers return to their defaults, grid restarts at row 0, column 0.
// Depends on hgm_pkg, hgm_mul and hgm_div.
module heightmap_grid_mesh_generator
#(
    parameter int MAX_DIM   = hgm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = hgm_pkg::FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [hgm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [hgm_pkg::CFG_DATA_W-1:0]         cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [hgm_pkg::SAMPLE_W-1:0]    height_sample,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [hgm_pkg::POS_XZ_W-1:0]           pos_x,
    output logic signed [hgm_pkg::POS_Y_W-1:0]     pos_y,
    output logic [hgm_pkg::POS_XZ_W-1:0]           pos_z,
    output logic [hgm_pkg::MAP_W-1:0]              map_s,
    output logic signed [hgm_pkg::MAP_W-1:0]       map_t,
    output logic [hgm_pkg::TILE_W-1:0]             tile_s,
    output logic [hgm_pkg::TILE_W-1:0]             tile_t,
    output logic                                   quad_valid,
    output logic [hgm_pkg::IDX_W-1:0]              corner_a,
    output logic [hgm_pkg::IDX_W-1:0]              corner_b,
    output logic [hgm_pkg::IDX_W-1:0]              corner_c,
    output logic [hgm_pkg::IDX_W-1:0]              corner_d
);
    import hgm_pkg::*;

    // Counter width holds MAX_DIM-1, size width holds MAX_DIM itself
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int CNX_W = CNT_W + 1;
    localparam int FR_W  = FRAC_BITS + 1;
    localparam logic [31:0] TILE_THREE = 32'(TILE_OFFSET) << FRAC_BITS;

    // Sequencer: three multiplies, two divisions, then hand off to the output register
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MX   = 7'b0000010,
        ST_MY   = 7'b0000100,
        ST_MZ   = 7'b0001000,
        ST_DS   = 7'b0010000,
        ST_DT   = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [DIM_W-1:0]  num_rows_reg;
    logic [DIM_W-1:0]  num_cols_reg;
    logic [STEP_W-1:0] row_step_reg;
    logic [STEP_W-1:0] col_step_reg;
    logic [STEP_W-1:0] height_scale_reg;

    // Grid position state
    logic [CNT_W-1:0]  row_cnt_reg;
    logic [CNT_W-1:0]  row_cnt_next;
    logic [CNT_W-1:0]  col_cnt_reg;
    logic [CNT_W-1:0]  col_cnt_next;
    logic [IDX_W-1:0]  vidx_reg;
    logic [IDX_W-1:0]  vidx_next;
    logic              restart;

    // Captured item
    logic [CNT_W-1:0]        item_row_reg;
    logic [CNT_W-1:0]        item_col_reg;
    logic [IDX_W-1:0]        item_a_reg;
    logic [SAMPLE_W-1:0]     sample_reg;

    // Intermediate results
    logic [POS_XZ_W-1:0]     px_reg;
    logic [POS_Y_W-1:0]      py_reg;
    logic [POS_XZ_W-1:0]     pz_reg;
    logic [FR_W-1:0]         frac_s_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [POS_XZ_W-1:0]     pos_x_reg;
    logic [POS_Y_W-1:0]      pos_y_reg;
    logic [POS_XZ_W-1:0]     pos_z_reg;
    logic [MAP_W-1:0]        map_s_reg;
    logic [MAP_W-1:0]        map_t_reg;
    logic [TILE_W-1:0]       tile_s_reg;
    logic [TILE_W-1:0]       tile_t_reg;
    logic                    quad_reg;
    logic [IDX_W-1:0]        corner_a_reg;
    logic [IDX_W-1:0]        corner_b_reg;
    logic [IDX_W-1:0]        corner_c_reg;
    logic [IDX_W-1:0]        corner_d_reg;

    logic                    in_xfer;
    logic                    load_out;

    // Clamped grid size
    logic [31:0]             rows_w;
    logic [31:0]             cols_w;
    logic [SZ_W-1:0]         rows_c;
    logic [SZ_W-1:0]         cols_c;
    logic [SZ_W-1:0]         rows_m1;
    logic [SZ_W-1:0]         cols_m1;

    // Shared multiplier
    logic                    mul_en;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    // Shared divider
    logic                    div_start;
    logic [SZ_W-1:0]         div_num;
    logic [SZ_W-1:0]         div_den;
    logic                    div_done;
    logic [FR_W-1:0]         div_quo;

    // Result assembly
    logic [31:0]             s_wide;
    logic [31:0]             t_wide;
    logic                    quad;
    logic [IDX_W-1:0]        cols_ext;
    logic [CNX_W-1:0]        col_inc;
    logic [CNX_W-1:0]        row_inc;

    //------------------------------------------------------------------
    // Grid size: clamp into 2..MAX_DIM
    //------------------------------------------------------------------
    assign rows_w = 32'(num_rows_reg);
    assign cols_w = 32'(num_cols_reg);

    always_comb
    begin
        priority if (rows_w < 32'd2)
            rows_c = SZ_W'(2);
        else if (rows_w > 32'(MAX_DIM))
            rows_c = SZ_W'(MAX_DIM);
        else
            rows_c = SZ_W'(rows_w);

        priority if (cols_w < 32'd2)
            cols_c = SZ_W'(2);
        else if (cols_w > 32'(MAX_DIM))
            cols_c = SZ_W'(MAX_DIM);
        else
            cols_c = SZ_W'(cols_w);
    end

    assign rows_m1 = rows_c - SZ_W'(1);
    assign cols_m1 = cols_c - SZ_W'(1);

    //------------------------------------------------------------------
    // Handshakes
    //------------------------------------------------------------------
    // Accept a new sample whenever the datapath is free; a finished result
    // may still wait in the output register meanwhile.
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MZ;
            ST_MZ:   state_next = ST_DS;
            ST_DS:   if (div_done) state_next = ST_DT;
            ST_DT:   if (div_done) state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // Multiplier operand select: x in MX, y in MY, z in MZ.
    // The product is registered in hgm_mul and held while no multiply state is active.
    //------------------------------------------------------------------
    assign mul_en = (state_reg == ST_MX) || (state_reg == ST_MY) || (state_reg == ST_MZ);

    always_comb
    begin
        unique case (state_reg)
            ST_MY:
            begin
                mul_a = $signed({sample_reg[SAMPLE_W-1], sample_reg});
                mul_b = $signed({height_scale_reg[STEP_W-1], height_scale_reg});
            end
            ST_MZ:
            begin
                mul_a = $signed(MUL_W'(item_col_reg));
                mul_b = $signed({1'b0, col_step_reg});
            end
            default:
            begin
                mul_a = $signed(MUL_W'(item_row_reg));
                mul_b = $signed({1'b0, row_step_reg});
            end
        endcase
    end

    hgm_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    //------------------------------------------------------------------
    // Divider: row/(rows-1) first, then col/(cols-1)
    //------------------------------------------------------------------
    assign div_start = (state_reg == ST_MZ) || ((state_reg == ST_DS) && div_done);
    assign div_num   = (state_reg == ST_MZ) ? SZ_W'(item_row_reg) : SZ_W'(item_col_reg);
    assign div_den   = (state_reg == ST_MZ) ? rows_m1 : cols_m1;

    hgm_div
    #(
        .SZ_W      (SZ_W),
        .FRAC_BITS (FRAC_BITS)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    //------------------------------------------------------------------
    // Grid counters: advance on each input transfer, wrap at grid end
    //------------------------------------------------------------------
    assign restart = cfg_we &&
                     ((cfg_index == CFG_NUM_ROWS) || (cfg_index == CFG_NUM_COLS));
    assign col_inc = CNX_W'(col_cnt_reg) + CNX_W'(1);
    assign row_inc = CNX_W'(row_cnt_reg) + CNX_W'(1);

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        vidx_next    = vidx_reg;
        if (restart)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
            vidx_next    = '0;
        end
        else if (in_xfer)
        begin
            vidx_next    = vidx_reg + IDX_W'(1);
            col_cnt_next = col_inc[CNT_W-1:0];
            if (col_inc >= CNX_W'(cols_c))
            begin
                col_cnt_next = '0;
                row_cnt_next = row_inc[CNT_W-1:0];
                if (row_inc >= CNX_W'(rows_c))
                begin
                    row_cnt_next = '0;
                    vidx_next    = '0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Result assembly, from the captured products and fractions
    //------------------------------------------------------------------
    assign s_wide   = 32'(frac_s_reg);
    assign t_wide   = 32'(div_quo);
    assign quad     = (SZ_W'(item_row_reg) < rows_m1) && (SZ_W'(item_col_reg) < cols_m1);
    assign cols_ext = IDX_W'(cols_c);

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            num_rows_reg     <= NUM_ROWS_RST;
            num_cols_reg     <= NUM_COLS_RST;
            row_step_reg     <= ROW_STEP_RST;
            col_step_reg     <= COL_STEP_RST;
            height_scale_reg <= HEIGHT_SCALE_RST;
            row_cnt_reg      <= '0;
            col_cnt_reg      <= '0;
            vidx_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            vidx_reg      <= vidx_next;
            if (cfg_we)
            begin
                // drop writes to unknown indexes
                unique case (cfg_index)
                    CFG_NUM_ROWS:     num_rows_reg     <= cfg_data[DIM_W-1:0];
                    CFG_NUM_COLS:     num_cols_reg     <= cfg_data[DIM_W-1:0];
                    CFG_ROW_STEP:     row_step_reg     <= cfg_data[STEP_W-1:0];
                    CFG_COL_STEP:     col_step_reg     <= cfg_data[STEP_W-1:0];
                    CFG_HEIGHT_SCALE: height_scale_reg <= cfg_data[STEP_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_row_reg <= row_cnt_reg;
            item_col_reg <= col_cnt_reg;
            item_a_reg   <= vidx_reg;
            sample_reg   <= height_sample;
        end
        if (state_reg == ST_MY)
            px_reg <= POS_XZ_W'(mul_p);
        if (state_reg == ST_MZ)
            py_reg <= POS_Y_W'(mul_p);
        if ((state_reg == ST_DS) && div_done)
        begin
            pz_reg     <= POS_XZ_W'(mul_p);
            frac_s_reg <= div_quo;
        end
        if (load_out)
        begin
            // the column fraction is still held at the divider output
            pos_x_reg  <= px_reg;
            pos_y_reg  <= py_reg;
            pos_z_reg  <= pz_reg;
            map_s_reg  <= MAP_W'(s_wide);
            map_t_reg  <= MAP_W'(32'd0 - t_wide);
            tile_s_reg <= TILE_W'(s_wide + TILE_THREE);
            tile_t_reg <= TILE_W'(t_wide + TILE_THREE);
            quad_reg   <= quad;
            if (quad)
            begin
                corner_a_reg <= item_a_reg;
                corner_b_reg <= item_a_reg + IDX_W'(1);
                corner_c_reg <= item_a_reg + cols_ext;
                corner_d_reg <= item_a_reg + cols_ext + IDX_W'(1);
            end
            else
            begin
                corner_a_reg <= '0;
                corner_b_reg <= '0;
                corner_c_reg <= '0;
                corner_d_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign map_s      = map_s_reg;
    assign map_t      = map_t_reg;
    assign tile_s     = tile_s_reg;
    assign tile_t     = tile_t_reg;
    assign quad_valid = quad_reg;
    assign corner_a   = corner_a_reg;
    assign corner_b   = corner_b_reg;
    assign corner_c   = corner_c_reg;
    assign corner_d   = corner_d_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DS) || (state_reg == ST_DT)))
        else $error("divider finished outside a division state");

    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        SZ_W'(col_cnt_reg) < cols_c)
        else $error("column counter beyond grid width");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        SZ_W'(row_cnt_reg) < rows_c)
        else $error("row counter beyond grid height");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register was full");

    a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !quad_reg) |->
            ((corner_a_reg == '0) && (corner_d_reg == '0)))
        else $error("corner indexes set without a quad");

endmodule

FILE: hdl/hgm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hgm_pkg for the operand width.
module hgm_mul
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hgm_pkg::MUL_W-1:0]    a,
    input  logic signed [hgm_pkg::MUL_W-1:0]    b,
    output logic signed [2*hgm_pkg::MUL_W-1:0]  p
);
    import hgm_pkg::*;

    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [2*MUL_W-1:0] prod_next;

    assign prod_next = a * b;

    // hold the product while the sequencer is elsewhere
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign p = prod_reg;

endmodule

FILE: hdl/hgm_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den).
// Requires num <= den and den >= 1. Depends on hgm_pkg for parameter defaults.
module hgm_div
#(
    parameter int SZ_W      = $clog2(hgm_pkg::MAX_DIM_DEF + 1),
    parameter int FRAC_BITS = hgm_pkg::FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SZ_W-1:0]      num,
    input  logic [SZ_W-1:0]      den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quo
);
    localparam int ITER  = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [SZ_W:0]      rem_reg;
    logic [SZ_W-1:0]    den_reg;
    logic [FRAC_BITS:0] quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               run_reg;
    logic               run_next;
    logic               done_reg;
    logic               done_next;

    logic [SZ_W:0]      den_ext;
    logic [SZ_W:0]      diff;
    logic               ge;
    logic [SZ_W:0]      rem_sel;
    logic               last_iter;

    assign den_ext   = {1'b0, den_reg};
    assign diff      = rem_reg - den_ext;
    assign ge        = (rem_reg >= den_ext);
    assign rem_sel   = ge ? diff : rem_reg;
    assign last_iter = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(ITER);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (last_iter)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // remainder stays below 2*den, so one spare bit is enough
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= {rem_sel[SZ_W-1:0], 1'b0};
            quo_reg <= {quo_reg[FRAC_BITS-1:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: dv/hgm_tb_pkg.sv
`timescale 1ns / 1ps
// Vertex scoreboard for the heightmap grid mesh generator testbench: predicts each
// vertex from its own copy of the registers and grid position. Depends on hgm_pkg.
package hgm_tb_pkg;
    import hgm_pkg::*;

    typedef struct {
        logic [POS_XZ_W-1:0] pos_x;
        logic [POS_Y_W-1:0]  pos_y;
        logic [POS_XZ_W-1:0] pos_z;
        logic [MAP_W-1:0]    map_s;
        logic [MAP_W-1:0]    map_t;
        logic [TILE_W-1:0]   tile_s;
        logic [TILE_W-1:0]   tile_t;
        logic                quad_valid;
        logic [IDX_W-1:0]    corner_a;
        logic [IDX_W-1:0]    corner_b;
        logic [IDX_W-1:0]    corner_c;
        logic [IDX_W-1:0]    corner_d;
    } mesh_vertex_t;

    class vertex_scoreboard;
        logic [DIM_W-1:0]  num_rows;
        logic [DIM_W-1:0]  num_cols;
        logic [STEP_W-1:0] row_step;
        logic [STEP_W-1:0] col_step;
        logic [STEP_W-1:0] height_scale;
        int unsigned       row_pos;
        int unsigned       col_pos;
        logic [IDX_W-1:0]  vertex_index;
        mesh_vertex_t      expected_vertices[$];
        int                errors;

        function new();
            num_rows     = NUM_ROWS_RST;
            num_cols     = NUM_COLS_RST;
            row_step     = ROW_STEP_RST;
            col_step     = COL_STEP_RST;
            height_scale = HEIGHT_SCALE_RST;
            errors       = 0;
            restart_grid();
        endfunction

        function void restart_grid();
            row_pos      = 0;
            col_pos      = 0;
            vertex_index = '0;
        endfunction

        function int unsigned grid_dim(logic [DIM_W-1:0] v);
            if (v < 2)
                return 2;
            if (v > MAX_DIM_DEF)
                return MAX_DIM_DEF;
            return 32'(v);
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_ROWS:
                begin
                    num_rows = data[DIM_W-1:0];
                    restart_grid();
                end
                CFG_NUM_COLS:
                begin
                    num_cols = data[DIM_W-1:0];
                    restart_grid();
                end
                CFG_ROW_STEP:     row_step = data;
                CFG_COL_STEP:     col_step = data;
                CFG_HEIGHT_SCALE: height_scale = data;
                default:          ;
            endcase
        endfunction

        function void predict_vertex(logic [SAMPLE_W-1:0] smp);
            int unsigned     rows;
            int unsigned     cols;
            longint unsigned s_frac;
            longint unsigned t_frac;
            longint unsigned tile_base;
            longint          y;
            mesh_vertex_t    v;
            rows      = grid_dim(num_rows);
            cols      = grid_dim(num_cols);
            y         = longint'($signed(smp)) * longint'($signed(height_scale));
            s_frac    = 64'(row_pos);
            s_frac    = (s_frac << FRAC_BITS_DEF) / 64'(rows - 1);
            t_frac    = 64'(col_pos);
            t_frac    = (t_frac << FRAC_BITS_DEF) / 64'(cols - 1);
            tile_base = 64'(TILE_OFFSET);
            tile_base = tile_base << FRAC_BITS_DEF;

            v.pos_x      = POS_XZ_W'(64'(row_pos) * 64'(row_step));
            v.pos_y      = POS_Y_W'(y);
            v.pos_z      = POS_XZ_W'(64'(col_pos) * 64'(col_step));
            v.map_s      = MAP_W'(s_frac);
            v.map_t      = MAP_W'(-t_frac);
            v.tile_s     = TILE_W'(s_frac + tile_base);
            v.tile_t     = TILE_W'(t_frac + tile_base);
            v.quad_valid = (row_pos < rows - 1) && (col_pos < cols - 1);
            if (v.quad_valid)
            begin
                v.corner_a = vertex_index;
                v.corner_b = IDX_W'(vertex_index + 1);
                v.corner_c = IDX_W'(vertex_index + cols);
                v.corner_d = IDX_W'(vertex_index + cols + 1);
            end
            else
            begin
                v.corner_a = '0;
                v.corner_b = '0;
                v.corner_c = '0;
                v.corner_d = '0;
            end
            expected_vertices.push_back(v);

            // Advance in row-major order; wrap to the first sample after the last
            vertex_index = IDX_W'(vertex_index + 1);
            col_pos++;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows)
                begin
                    row_pos      = 0;
                    vertex_index = '0;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_vertex(mesh_vertex_t got);
            mesh_vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: vertex with nothing expected: expected none, actual pos_x 0x%0h",
                         $time, got.pos_x);
                errors++;
                return;
            end
            want = expected_vertices.pop_front();
            compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("pos_z", 32'(want.pos_z), 32'(got.pos_z));
            compare_field("map_s", 32'(want.map_s), 32'(got.map_s));
            compare_field("map_t", 32'(want.map_t), 32'(got.map_t));
            compare_field("tile_s", 32'(want.tile_s), 32'(got.tile_s));
            compare_field("tile_t", 32'(want.tile_t), 32'(got.tile_t));
            compare_field("quad_valid", 32'(want.quad_valid), 32'(got.quad_valid));
            compare_field("corner_a", 32'(want.corner_a), 32'(got.corner_a));
            compare_field("corner_b", 32'(want.corner_b), 32'(got.corner_b));
            compare_field("corner_c", 32'(want.corner_c), 32'(got.corner_c));
            compare_field("corner_d", 32'(want.corner_d), 32'(got.corner_d));
        endfunction
    endclass

endpackage

FILE: dv/tb_heightmap_grid_mesh_generator.sv
`timescale 1ns / 1ps
// Top-level testbench for heightmap_grid_mesh_generator: directed and random height
// samples under several idle and stall mixes. Depends on hgm_pkg and hgm_tb_pkg.
module tb_heightmap_grid_mesh_generator;
    import hgm_pkg::*;
    import hgm_tb_pkg::*;

    // Input transfer to output valid of the generator
    localparam int LATENCY     = 2 * FRAC_BITS_DEF + 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 16;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  height_sample = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic [POS_XZ_W-1:0]         pos_x;
    logic signed [POS_Y_W-1:0]   pos_y;
    logic [POS_XZ_W-1:0]         pos_z;
    logic [MAP_W-1:0]            map_s;
    logic signed [MAP_W-1:0]     map_t;
    logic [TILE_W-1:0]           tile_s;
    logic [TILE_W-1:0]           tile_t;
    logic                        quad_valid;
    logic [IDX_W-1:0]            corner_a;
    logic [IDX_W-1:0]            corner_b;
    logic [IDX_W-1:0]            corner_c;
    logic [IDX_W-1:0]            corner_d;

    // Percent chance per cycle that the sender idles or the receiver stalls
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       cycle_count    = 0;
    vertex_scoreboard  sb;
    mesh_vertex_t      got_vertex;

    heightmap_grid_mesh_generator DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .height_sample (height_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .map_s         (map_s),
        .map_t         (map_t),
        .tile_s        (tile_s),
        .tile_t        (tile_t),
        .quad_valid    (quad_valid),
        .corner_a      (corner_a),
        .corner_b      (corner_b),
        .corner_c      (corner_c),
        .corner_d      (corner_d)
    );

    always #1 clk = ~clk;

    // Bound the run: a lost transfer or a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("heightmap_grid_mesh_generator test failed");
            $finish;
        end
    end

    // Receiver: check each output transfer against the oldest predicted vertex,
    // then pick ready for the next cycle. Values read here are the ones the
    // block saw at this edge, since every input is driven nonblocking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_vertex.pos_x      = pos_x;
                got_vertex.pos_y      = pos_y;
                got_vertex.pos_z      = pos_z;
                got_vertex.map_s      = map_s;
                got_vertex.map_t      = map_t;
                got_vertex.tile_s     = tile_s;
                got_vertex.tile_t     = tile_t;
                got_vertex.quad_valid = quad_valid;
                got_vertex.corner_a   = corner_a;
                got_vertex.corner_b   = corner_b;
                got_vertex.corner_c   = corner_c;
                got_vertex.corner_d   = corner_d;
                sb.check_vertex(got_vertex);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write one register; hold the enable for a single edge, then drop it for
    // one cycle so back-to-back writes never touch cfg_we twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_reg_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one sample. Valid stays high from the previous transfer when no
    // idle cycle falls in between, so it is never lowered and raised in one step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        height_sample <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.predict_vertex(smp);
    endtask

    // Drop valid and hold off until every predicted vertex has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct  = 79;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 79;
            end
            default:
            begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
        endcase
    endtask

    // Grid sizes: mostly small so grids wrap often, sometimes out of range
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd1024;
            3:       return 16'd2047;
            4:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(8, 2));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        if ($urandom_range(1))
            write_reg(CFG_NUM_ROWS, pick_dim());
        if ($urandom_range(1))
            write_reg(CFG_NUM_COLS, pick_dim());
        if ($urandom_range(1))
            write_reg(CFG_ROW_STEP, pick_word());
        if ($urandom_range(1))
            write_reg(CFG_COL_STEP, pick_word());
        if ($urandom_range(1))
            write_reg(CFG_HEIGHT_SCALE, pick_word());
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_HEIGHT_SCALE) + 1)),
                      CFG_DATA_W'($urandom));
    endtask

    task automatic directed_tests();
        // Default 2x2 grid: sample extremes, edge vertices with no quad, wrap
        send_sample(16'h7FFF);
        drain_results();
        // Undecoded indexes must leave registers and grid position alone
        for (int i = int'(CFG_HEIGHT_SCALE) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain_results();

        // Sizes below and above range clamp; steps and scale at their extremes
        write_reg(CFG_NUM_ROWS, 16'h0000);
        write_reg(CFG_NUM_COLS, 16'hFFFF);
        write_reg(CFG_ROW_STEP, 16'hFFFF);
        write_reg(CFG_COL_STEP, 16'hFFFF);
        write_reg(CFG_HEIGHT_SCALE, 16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain_results();

        // Rewrite the grid size mid-grid: the grid restarts at vertex zero
        write_reg(CFG_NUM_COLS, 16'd3);
        write_reg(CFG_NUM_ROWS, 16'd1);
        repeat (4) send_sample(SAMPLE_W'($urandom));
        drain_results();

        // Zero steps leave x and z positions at zero; texture coordinates still advance
        write_reg(CFG_ROW_STEP, 16'h0000);
        write_reg(CFG_COL_STEP, 16'h0000);
        write_reg(CFG_HEIGHT_SCALE, 16'h7FFF);
        write_reg(CFG_NUM_ROWS, 16'd3);
        repeat (4) send_sample(SAMPLE_W'($urandom));
        drain_results();

        // Row count just past the maximum
        write_reg(CFG_NUM_ROWS, 16'd1025);
        write_reg(CFG_ROW_STEP, 16'h0101);
        repeat (4) send_sample(SAMPLE_W'($urandom));
        drain_results();
    endtask

    task automatic random_tests();
        int n_items;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            set_idle_mode(idle_mode_t'(phase % 4));
            randomize_config();
            n_items = $urandom_range(70, 30);
            for (int k = 0; k < n_items; k++)
            begin
                // Now and then hold the sender until the block has emptied
                if ($urandom_range(49) == 0)
                    drain_results();
                send_sample(SAMPLE_W'($urandom));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_tests();
        random_tests();
        drain_results();

        // Watch for stray output transfers after the last expected vertex
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("heightmap_grid_mesh_generator test passed");
        else
            $display("heightmap_grid_mesh_generator test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hgm_pkg.sv
hdl/hgm_mul.sv
hdl/hgm_div.sv
hdl/heightmap_grid_mesh_generator.sv
dv/hgm_tb_pkg.sv
dv/tb_heightmap_grid_mesh_generator.sv
